### design/tar_pkg.sv
package tar_pkg;

  localparam int INDEX_W = 6;
  localparam int RANK_W  = 7;
  localparam int SCORE_W = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH_A,
    ST_LATCH_A,
    ST_COMPARE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RD_ITEM,
    RD_FIRST,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    clear_set;
    logic    a_inc;
    logic    b_clr;
    logic    b_inc;
    logic    sa_latch;
    logic    acc_clr;
    logic    acc_en;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic a_last;
    logic b_last;
  } sts_t;

endpackage

### design/tie_averaged_ranking.sv
// Channel | Handshake           | Payload
// input   | in_valid / in_stall | score, last_in
// output  | out_valid/out_stall | item_index, rank_doubled, overflow, last_out
//
// Load: one score per cycle into the score memory until last_in.
// Rank: per item, FETCH_A and LATCH_A fetch its score, COMPARE steps over every
// stored score through the single memory read port, then EMIT holds the result.
// Input stalls from the accepted last item until the final result leaves.
// Reset (rst, synchronous) empties the set and returns to loading.
module tie_averaged_ranking #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tar_pkg::SCORE_W-1:0] score,
  input  logic                        last_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tar_pkg::INDEX_W-1:0] item_index,
  output logic [tar_pkg::RANK_W-1:0]  rank_doubled,
  output logic                        overflow,
  output logic                        last_out
);
  import tar_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tar_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .score        (score),
    .item_index   (item_index),
    .rank_doubled (rank_doubled),
    .overflow     (overflow),
    .last_out     (last_out)
  );

endmodule

### design/tar_ctrl.sv
module tar_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          last_in,
  output logic          out_valid,
  input  logic          out_stall,
  input  tar_pkg::sts_t sts,
  output tar_pkg::cmd_t cmd
);
  import tar_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid && (state == ST_LOAD);
  assign out_acc = (state == ST_EMIT) && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_acc && last_in) begin
          state_next = ST_FETCH_A;
        end
      end
      ST_FETCH_A: state_next = ST_LATCH_A;
      ST_LATCH_A: state_next = ST_COMPARE;
      ST_COMPARE: begin
        if (sts.b_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          state_next = sts.a_last ? ST_LOAD : ST_FETCH_A;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.load      = 1'b0;
    cmd.clear_set = 1'b0;
    cmd.a_inc     = 1'b0;
    cmd.b_clr     = 1'b0;
    cmd.b_inc     = 1'b0;
    cmd.sa_latch  = 1'b0;
    cmd.acc_clr   = 1'b0;
    cmd.acc_en    = 1'b0;
    cmd.rd_sel    = RD_ITEM;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_acc;
      end
      ST_FETCH_A: begin
        cmd.rd_sel = RD_ITEM;
      end
      ST_LATCH_A: begin
        cmd.rd_sel   = RD_FIRST;
        cmd.sa_latch = 1'b1;
        cmd.acc_clr  = 1'b1;
        cmd.b_clr    = 1'b1;
      end
      ST_COMPARE: begin
        cmd.rd_sel = RD_NEXT;
        cmd.acc_en = 1'b1;
        cmd.b_inc  = 1'b1;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.a_inc     = out_acc && !sts.a_last;
        cmd.clear_set = out_acc && sts.a_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### design/tar_dpath.sv
module tar_dpath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tar_pkg::cmd_t                 cmd,
  output tar_pkg::sts_t                 sts,
  input  logic [tar_pkg::SCORE_W-1:0]   score,
  output logic [tar_pkg::INDEX_W-1:0]   item_index,
  output logic [tar_pkg::RANK_W-1:0]    rank_doubled,
  output logic                          overflow,
  output logic                          last_out
);
  import tar_pkg::*;

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [SCORE_W-1:0] mem [MAX_ITEMS];
  logic [SCORE_W-1:0] rdata;
  logic [SCORE_W-1:0] sa;
  logic [IW-1:0]      raddr;
  logic [CW-1:0]      count;
  logic               ovf;
  logic [IW-1:0]      a;
  logic [IW-1:0]      b;
  logic [IW-1:0]      less;
  logic [CW-1:0]      equal;
  logic               full;
  logic [CW-1:0]      count_m1;

  assign full     = (count == CW'(MAX_ITEMS));
  assign count_m1 = count - CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_ITEM:  raddr = a;
      RD_FIRST: raddr = '0;
      RD_NEXT:  raddr = b + IW'(1);
      default:  raddr = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[IW-1:0]] <= score;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      a     <= '0;
    end else begin
      if (cmd.clear_set) begin
        count <= '0;
        ovf   <= 1'b0;
        a     <= '0;
      end else begin
        if (cmd.load) begin
          if (full) begin
            ovf <= 1'b1;
          end else begin
            count <= count + CW'(1);
          end
        end
        if (cmd.a_inc) begin
          a <= a + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sa_latch) begin
      sa <= rdata;
    end
    if (cmd.b_clr) begin
      b <= '0;
    end else if (cmd.b_inc) begin
      b <= b + IW'(1);
    end
    if (cmd.acc_clr) begin
      less  <= '0;
      equal <= '0;
    end else if (cmd.acc_en) begin
      if (rdata < sa) begin
        less <= less + IW'(1);
      end else if (rdata == sa) begin
        equal <= equal + CW'(1);
      end
    end
  end

  assign sts.a_last = (CW'(a) == count_m1);
  assign sts.b_last = (CW'(b) == count_m1);

  assign item_index   = INDEX_W'(a);
  assign rank_doubled = RANK_W'({less, 1'b0}) + RANK_W'(equal) - RANK_W'(1);
  assign overflow     = ovf;
  assign last_out     = sts.a_last;

endmodule
